[design/gamepad_serial_poll_master_assert.svh]
// ----------------------------------------------------------------------------
// Gamepad serial poll master: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef GAMEPAD_SERIAL_POLL_MASTER_ASSERT_SVH
`define GAMEPAD_SERIAL_POLL_MASTER_ASSERT_SVH

// expression holds at every edge
`define GSPM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// consequent holds at the edge after the antecedent
`define GSPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/gspm_pkg.sv]
// ----------------------------------------------------------------------------
// gspm_pkg
// Types, constants and command tables of the gamepad serial poll master.
// ----------------------------------------------------------------------------
package gspm_pkg;

    localparam int DEF_MAX_FRAME_BYTES = 9;
    localparam int DEF_TIMER_BITS      = 16;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CAP_BYTES = 6;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HALF_BIT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BYTE_GAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_END = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_GAP = 2'd3;

    localparam logic [CFG_W-1:0] RST_HALF_BIT  = 16'd50;
    localparam logic [CFG_W-1:0] RST_BYTE_GAP  = 16'd100;
    localparam logic [CFG_W-1:0] RST_FRAME_END = 16'd1000;
    localparam logic [CFG_W-1:0] RST_FRAME_GAP = 16'd10000;

    // frame kinds
    localparam logic [1:0] FUNC_POLL       = 2'd0;
    localparam logic [1:0] FUNC_ENTER_CFG  = 2'd1;
    localparam logic [1:0] FUNC_EXIT_CFG   = 2'd2;
    localparam logic [1:0] FUNC_SET_ANALOG = 2'd3;

    // command bytes
    localparam logic [7:0] CMD_HEADER  = 8'h01;
    localparam logic [7:0] CMD_POLL    = 8'h42;
    localparam logic [7:0] CMD_CONFIG  = 8'h43;
    localparam logic [7:0] CMD_ANALOG  = 8'h44;
    localparam logic [7:0] CMD_PAD     = 8'h5A;
    localparam logic [7:0] CMD_LOCK    = 8'h03;
    localparam logic [7:0] CMD_ONE     = 8'h01;
    localparam logic [7:0] CMD_ZERO    = 8'h00;

    localparam logic [7:0] BUTTON_IDLE = 8'hFF;
    localparam logic [7:0] STICK_IDLE  = 8'd128;

    typedef struct packed {
        logic [CFG_W-1:0] half_bit_ticks;
        logic [CFG_W-1:0] byte_gap_ticks;
        logic [CFG_W-1:0] frame_end_ticks;
        logic [CFG_W-1:0] frame_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic       att_n;
        logic       cmd_out;
        logic       clk_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] buttons_low;
        logic [7:0] buttons_high;
        logic [7:0] right_x;
        logic [7:0] right_y;
        logic [7:0] left_x;
        logic [7:0] left_y;
    } t_res;

    function automatic logic [4:0] kind_len(input logic [1:0] kind);
        logic [4:0] len;
        case (kind)
            FUNC_ENTER_CFG: len = 5'd5;
            default:        len = 5'd9;
        endcase
        return len;
    endfunction

    // command byte idx of a frame kind; zero past the end
    function automatic logic [7:0] kind_byte(input logic [1:0] kind, input logic [3:0] idx);
        logic [7:0] b;
        b = CMD_ZERO;
        case (idx)
            4'd0: b = CMD_HEADER;
            4'd1: begin
                case (kind)
                    FUNC_POLL:       b = CMD_POLL;
                    FUNC_SET_ANALOG: b = CMD_ANALOG;
                    default:         b = CMD_CONFIG;
                endcase
            end
            4'd3: begin
                if (kind == FUNC_ENTER_CFG || kind == FUNC_SET_ANALOG) begin
                    b = CMD_ONE;
                end
            end
            4'd4: begin
                case (kind)
                    FUNC_EXIT_CFG:   b = CMD_PAD;
                    FUNC_SET_ANALOG: b = CMD_LOCK;
                    default:         b = CMD_ZERO;
                endcase
            end
            4'd5, 4'd6, 4'd7, 4'd8: begin
                if (kind == FUNC_EXIT_CFG) begin
                    b = CMD_PAD;
                end
            end
            default: b = CMD_ZERO;
        endcase
        return b;
    endfunction

endpackage

[design/gspm_if.sv]
// ----------------------------------------------------------------------------
// gspm_if
// Tick and result channels of the gamepad serial poll master.
// ----------------------------------------------------------------------------
interface gspm_in_if;
    logic       valid;
    logic       ready;
    logic       start_req;
    logic [1:0] func;
    logic       data_in;

    modport source (output valid, start_req, func, data_in, input ready);
    modport sink   (input valid, start_req, func, data_in, output ready);
endinterface

interface gspm_out_if;
    logic       valid;
    logic       ready;
    logic       att_n;
    logic       cmd_out;
    logic       clk_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] buttons_low;
    logic [7:0] buttons_high;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;

    modport source (output valid, att_n, cmd_out, clk_out, busy_res, done_res,
                    buttons_low, buttons_high, right_x, right_y, left_x, left_y,
                    input ready);
    modport sink   (input valid, att_n, cmd_out, clk_out, busy_res, done_res,
                    buttons_low, buttons_high, right_x, right_y, left_x, left_y,
                    output ready);
endinterface

[design/gspm_core.sv]
// ----------------------------------------------------------------------------
// gspm_core
// Link sequencer: advances one tick per accepted beat, gives the line levels.
// ----------------------------------------------------------------------------
module gspm_core import gspm_pkg::*; #(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int TIMER_BITS      = DEF_TIMER_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_fire,
    input  logic       i_start,
    input  logic [1:0] i_func,
    input  logic       i_data,
    input  t_cfg       i_cfg,
    output t_res       o_res
);

    typedef enum logic [2:0] {
        PH_IDLE, PH_SETUP, PH_LOW, PH_GAP, PH_END, PH_FGAP
    } t_phase;

    localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [CW-1:0]         TMAX_EXT = CW'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [4:0]            MAXB     = 5'(MAX_FRAME_BYTES);
    localparam logic [TIMER_BITS-1:0] T_ONE    = TIMER_BITS'(1);

    // delays saturate at the timer's range
    function automatic logic [TIMER_BITS-1:0] clamp(input logic [CFG_W-1:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext > TMAX_EXT) begin
            ext = TMAX_EXT;
        end
        return ext[TIMER_BITS-1:0];
    endfunction

    t_phase                r_phase, n_phase;
    logic [1:0]            r_kind, n_kind;
    logic [TIMER_BITS-1:0] r_wait, n_wait;
    logic [3:0]            r_byte, n_byte;
    logic [2:0]            r_bit, n_bit;
    logic [7:0]            r_tx, n_tx;
    logic [7:0]            r_rx, n_rx;
    logic [7:0]            r_cap [CAP_BYTES];
    logic [7:0]            n_cap [CAP_BYTES];
    logic                  r_att, n_att;
    logic                  r_clk, n_clk;
    logic                  r_cmd, n_cmd;

    logic                  w_done;
    logic                  w_after;
    logic                  w_fgap;
    logic [TIMER_BITS-1:0] w_hb_wait;
    logic [TIMER_BITS-1:0] w_gap_wait;
    logic [TIMER_BITS-1:0] w_end_wait;
    logic [TIMER_BITS-1:0] w_fgap_wait;
    logic [4:0]            w_len;
    logic [4:0]            w_next_byte;
    logic [2:0]            w_cap_idx;

    assign w_hb_wait   = clamp((i_cfg.half_bit_ticks == '0) ? CFG_W'(1) : i_cfg.half_bit_ticks);
    assign w_gap_wait  = clamp(i_cfg.byte_gap_ticks);
    assign w_end_wait  = clamp(i_cfg.frame_end_ticks);
    assign w_fgap_wait = clamp(i_cfg.frame_gap_ticks);
    assign w_len       = (kind_len(r_kind) < MAXB) ? kind_len(r_kind) : MAXB;
    assign w_next_byte = {1'b0, r_byte} + 5'd1;
    assign w_cap_idx   = 3'(r_byte - 4'd3);

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_wait  = r_wait;
        n_byte  = r_byte;
        n_bit   = r_bit;
        n_tx    = r_tx;
        n_rx    = r_rx;
        n_cap   = r_cap;
        n_att   = r_att;
        n_clk   = r_clk;
        n_cmd   = r_cmd;
        w_done  = 1'b0;
        w_after = 1'b0;
        w_fgap  = 1'b0;

        if (i_fire) begin
            if (r_phase == PH_IDLE) begin
                if (i_start) begin
                    n_kind  = i_func;
                    n_byte  = '0;
                    n_att   = 1'b0;
                    n_clk   = 1'b1;
                    n_tx    = kind_byte(i_func, 4'd0);
                    n_rx    = '0;
                    n_bit   = '0;
                    n_cmd   = n_tx[0];
                    n_phase = PH_SETUP;
                    n_wait  = w_hb_wait;
                end
            end else if (r_wait > T_ONE) begin
                n_wait = r_wait - T_ONE;
            end else begin
                n_wait = '0;
                case (r_phase)
                    PH_SETUP: begin
                        n_clk   = 1'b0;
                        n_phase = PH_LOW;
                        n_wait  = w_hb_wait;
                    end
                    PH_LOW: begin
                        n_rx  = {i_data, r_rx[7:1]};
                        n_clk = 1'b1;
                        if (r_bit < 3'd7) begin
                            n_bit   = r_bit + 3'd1;
                            n_tx    = {1'b0, r_tx[7:1]};
                            n_cmd   = r_tx[1];
                            n_phase = PH_SETUP;
                            n_wait  = w_hb_wait;
                        end else begin
                            // polls keep bytes 3..8
                            if (r_kind == FUNC_POLL && r_byte >= 4'd3 && r_byte <= 4'd8) begin
                                n_cap[w_cap_idx] = n_rx;
                            end
                            n_wait = w_gap_wait;
                            if (w_gap_wait == '0) begin
                                w_after = 1'b1;
                            end else begin
                                n_phase = PH_GAP;
                            end
                        end
                    end
                    PH_GAP: begin
                        w_after = 1'b1;
                    end
                    PH_END: begin
                        n_att  = 1'b1;
                        w_fgap = 1'b1;
                    end
                    PH_FGAP: begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end

        if (w_after) begin
            if (w_next_byte < w_len) begin
                n_byte  = w_next_byte[3:0];
                n_tx    = kind_byte(r_kind, w_next_byte[3:0]);
                n_rx    = '0;
                n_bit   = '0;
                n_cmd   = n_tx[0];
                n_phase = PH_SETUP;
                n_wait  = w_hb_wait;
            end else begin
                n_cmd = 1'b0;
                if (r_kind == FUNC_POLL) begin
                    n_att   = 1'b1;
                    n_phase = PH_IDLE;
                    w_done  = 1'b1;
                end else begin
                    n_wait = w_end_wait;
                    if (w_end_wait == '0) begin
                        n_att  = 1'b1;
                        w_fgap = 1'b1;
                    end else begin
                        n_phase = PH_END;
                    end
                end
            end
        end

        if (w_fgap) begin
            n_wait = w_fgap_wait;
            if (w_fgap_wait == '0) begin
                n_phase = PH_IDLE;
                w_done  = 1'b1;
            end else begin
                n_phase = PH_FGAP;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_kind  <= '0;
            r_wait  <= '0;
            r_byte  <= '0;
            r_bit   <= '0;
            r_tx    <= '0;
            r_rx    <= '0;
            r_att   <= 1'b1;
            r_clk   <= 1'b1;
            r_cmd   <= 1'b0;
            r_cap[0] <= BUTTON_IDLE;
            r_cap[1] <= BUTTON_IDLE;
            for (int k = 2; k < CAP_BYTES; k++) begin
                r_cap[k] <= STICK_IDLE;
            end
        end else begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_wait  <= n_wait;
            r_byte  <= n_byte;
            r_bit   <= n_bit;
            r_tx    <= n_tx;
            r_rx    <= n_rx;
            r_att   <= n_att;
            r_clk   <= n_clk;
            r_cmd   <= n_cmd;
            r_cap   <= n_cap;
        end
    end

    // result of this tick: levels after the update
    always_comb begin
        o_res.att_n        = n_att;
        o_res.cmd_out      = n_cmd;
        o_res.clk_out      = n_clk;
        o_res.busy_res     = (n_phase != PH_IDLE);
        o_res.done_res     = w_done;
        o_res.buttons_low  = n_cap[0];
        o_res.buttons_high = n_cap[1];
        o_res.right_x      = n_cap[2];
        o_res.right_y      = n_cap[3];
        o_res.left_x       = n_cap[4];
        o_res.left_y       = n_cap[5];
    end

endmodule

[design/gamepad_serial_poll_master.sv]
// ----------------------------------------------------------------------------
// gamepad_serial_poll_master
// Pin-level master for a gamepad's synchronous serial link, one tick a beat.
// ----------------------------------------------------------------------------
//  channel   dir   beat contents
//  i_req     in    start_req, func, data_in (one timing tick)
//  o_res     out   att_n, cmd_out, clk_out, busy_res, done_res, captured bytes
//  i_cfg_*   in    write enable, register index, 16-bit data
//
//  One tick beat in, one result beat out; a new tick is taken every cycle
//  while i_req.ready is high. The sequencer updates its state in the cycle a
//  tick is accepted; that edge registers its result in the output stage.
//  A two-entry output stage (main + skid) keeps i_req.ready high while a
//  result waits; ready drops only when both entries are full.
//  Reset (sync, active low): idle, att_n and clk high, cmd low, buttons 0xFF,
//  sticks 128, config back to 50/100/1000/10000 ticks.
// ----------------------------------------------------------------------------
module gamepad_serial_poll_master import gspm_pkg::*; #(
    parameter int MAX_FRAME_BYTES = DEF_MAX_FRAME_BYTES,
    parameter int TIMER_BITS      = DEF_TIMER_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    gspm_in_if.sink              i_req,
    gspm_out_if.source           o_res,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

`include "gamepad_serial_poll_master_assert.svh"

    t_cfg r_cfg;
    t_res w_res;
    t_res r_main;
    t_res r_skid;
    logic r_main_vld;
    logic r_skid_vld;
    logic w_in_ready;
    logic w_in_fire;
    logic w_out_ready;

    assign w_in_ready  = !r_skid_vld;
    assign w_in_fire   = i_req.valid && w_in_ready;
    assign w_out_ready = o_res.ready;
    assign i_req.ready = w_in_ready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_bit_ticks  <= RST_HALF_BIT;
            r_cfg.byte_gap_ticks  <= RST_BYTE_GAP;
            r_cfg.frame_end_ticks <= RST_FRAME_END;
            r_cfg.frame_gap_ticks <= RST_FRAME_GAP;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_HALF_BIT:  r_cfg.half_bit_ticks  <= i_cfg_data;
                REG_BYTE_GAP:  r_cfg.byte_gap_ticks  <= i_cfg_data;
                REG_FRAME_END: r_cfg.frame_end_ticks <= i_cfg_data;
                REG_FRAME_GAP: r_cfg.frame_gap_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gspm_core #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .TIMER_BITS      (TIMER_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_in_fire),
        .i_start (i_req.start_req),
        .i_func  (i_req.func),
        .i_data  (i_req.data_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // output stage: main register drives the port, skid catches a stalled beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_vld <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_main_vld || w_out_ready) begin
            if (r_skid_vld) begin
                r_main_vld <= 1'b1;
                r_skid_vld <= w_in_fire;
            end else begin
                r_main_vld <= w_in_fire;
            end
        end else if (w_in_fire) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_main_vld || w_out_ready) begin
            if (r_skid_vld) begin
                r_main <= r_skid;
                r_skid <= w_res;
            end else begin
                r_main <= w_res;
            end
        end else if (w_in_fire) begin
            r_skid <= w_res;
        end
    end

    assign o_res.valid        = r_main_vld;
    assign o_res.att_n        = r_main.att_n;
    assign o_res.cmd_out      = r_main.cmd_out;
    assign o_res.clk_out      = r_main.clk_out;
    assign o_res.busy_res     = r_main.busy_res;
    assign o_res.done_res     = r_main.done_res;
    assign o_res.buttons_low  = r_main.buttons_low;
    assign o_res.buttons_high = r_main.buttons_high;
    assign o_res.right_x      = r_main.right_x;
    assign o_res.right_y      = r_main.right_y;
    assign o_res.left_x       = r_main.left_x;
    assign o_res.left_y       = r_main.left_y;

    // the skid entry is only ever filled behind a held main entry
    `GSPM_ASSERT_ALWAYS(a_skid_behind_main, !r_skid_vld || r_main_vld, "skid full, main empty")
    // a beat taken while the port stalls must land in the skid entry
    `GSPM_ASSERT_NEXT(a_stall_to_skid, w_in_fire && r_main_vld && !w_out_ready, r_skid_vld, "stalled beat lost")
    // a finished frame leaves the link idle with attention released
    `GSPM_ASSERT_ALWAYS(a_done_idle, !w_res.done_res || (!w_res.busy_res && w_res.att_n), "done while active")

endmodule
